### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Both sample on clock and are disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TSS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// Next-cycle implication.
`define TSS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

### rtl/tss_pkg.sv
`default_nettype none

package tss_pkg;

   localparam int ID_W     = 31;
   localparam int TYPE_W   = 3;
   localparam int OC_W     = 2;
   localparam int STATUS_W = 2;
   localparam int LIVE_W   = 11;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_SPAWN      = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_DISPATCH   = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_RUN_END    = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_CANCEL     = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_TAKE_DONE  = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_TAKE_PANIC = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_FLAG_OP    = 3'd6;
   localparam logic [TYPE_W-1:0] REQ_UNKNOWN    = 3'd7;

   // outcome codes, run end
   localparam logic [OC_W-1:0] OC_YIELD   = 2'd0;
   localparam logic [OC_W-1:0] OC_FINISH  = 2'd1;
   localparam logic [OC_W-1:0] OC_PANIC   = 2'd2;
   localparam logic [OC_W-1:0] OC_INVALID = 2'd3;

   // outcome codes, flag op
   localparam logic [OC_W-1:0] FLAG_READ        = 2'd0;
   localparam logic [OC_W-1:0] FLAG_MARK_RETURN = 2'd1;
   localparam logic [OC_W-1:0] FLAG_SELF_CANCEL = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_SLOT   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd3;

   // slot phases
   localparam logic [1:0] PH_READY     = 2'd0;
   localparam logic [1:0] PH_RUNNING   = 2'd1;
   localparam logic [1:0] PH_SUSPENDED = 2'd2;
   localparam logic [1:0] PH_DONE      = 2'd3;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_EVAL,
      S_OUT
   } tss_state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } rng_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } rng_stat_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     result_id;
      logic                cancelled_flag;
      logic                panicked_flag;
      logic                from_steal;
      logic [LIVE_W-1:0]   live_tasks;
      logic                work_pending;
   } rsp_payload_type;

endpackage

`default_nettype wire

### rtl/tss_req_if.sv
`default_nettype none

interface tss_req_if import tss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [ID_W-1:0]   task_id;
   logic [OC_W-1:0]   outcome;

   modport source (output valid, req_type, task_id, outcome, input ready);
   modport sink   (input valid, req_type, task_id, outcome, output ready);
endinterface

`default_nettype wire

### rtl/tss_rsp_if.sv
`default_nettype none

interface tss_rsp_if import tss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     result_id;
   logic                cancelled_flag;
   logic                panicked_flag;
   logic                from_steal;
   logic [LIVE_W-1:0]   live_tasks;
   logic                work_pending;

   modport source (output valid, status, result_id, cancelled_flag, panicked_flag,
                   from_steal, live_tasks, work_pending, input ready);
   modport sink   (input valid, status, result_id, cancelled_flag, panicked_flag,
                   from_steal, live_tasks, work_pending, output ready);
endinterface

`default_nettype wire

### rtl/tss_ring.sv
`default_nettype none

// Circular queue in a synchronous memory; pop registers the head entry.
module tss_ring import tss_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int DW    = 10
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire rng_ctrl_type  ctrl,
   input  wire logic [DW-1:0] push_data,
   output logic [DW-1:0]      rd_data,
   output rng_stat_type       stat
);

   localparam int AW = $clog2(DEPTH);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [AW:0]   count_ff, count_in;
   logic [AW+1:0] tail_sum;
   logic [AW-1:0] tail;

   always_comb begin
      tail_sum = (AW+2)'(head_ff) + (AW+2)'(count_ff);
      if (32'(tail_sum) >= DEPTH) begin
         tail = AW'(32'(tail_sum) - DEPTH);
      end else begin
         tail = AW'(tail_sum);
      end
      head_in  = head_ff;
      count_in = count_ff;
      if (ctrl.pop) begin
         head_in  = (32'(head_ff) == DEPTH - 1) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (ctrl.push) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail] <= push_data;
      end
      if (ctrl.pop) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   assign rd_data    = rd_data_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (32'(count_ff) >= DEPTH);

endmodule

`default_nettype wire

### rtl/task_slot_scheduler.sv
// Path: an accepted request goes to S_OUT directly or by way of S_FETCH (stack or ring
//   read) and S_EVAL (the slot-table read that follows it), and waits in S_OUT for a
//   free response register; take-panicked returns to S_FETCH for every stale panic-log
//   entry it drops. One request at a time: ready is high only in S_IDLE.
// Reset (synchronous): a clearing pass over every slot zeroes the slot table and
//   refills the free-slot stack; no request is taken until it ends.
`default_nettype none

module task_slot_scheduler import tss_pkg::*; #(
   parameter int SLOT_COUNT = 1024,
   parameter int SLOT_BITS  = 10,
   parameter int GEN_BITS   = 21
) (
   input wire logic clock,
   input wire logic reset,
   tss_req_if.sink   req_ch,
   tss_rsp_if.source rsp_ch
);

`include "assert_macros.svh"

   localparam int AW = $clog2(SLOT_COUNT);
   localparam int CW = AW + 1;

   // one slot-table entry
   typedef struct packed {
      logic [GEN_BITS-1:0] gen;
      logic                occ;
      logic [1:0]          phase;
      logic                creq;
      logic                cret;
      logic                pan;
   } entry_type;

   // Task id: generation above the slot field, cut to the id width.
   function automatic logic [ID_W-1:0] make_id(input logic [AW-1:0] s,
                                                input logic [GEN_BITS-1:0] g);
      logic [ID_W+GEN_BITS+SLOT_BITS-1:0] w;
      w = {{ID_W{1'b0}}, g, SLOT_BITS'(s)};
      return w[ID_W-1:0];
   endfunction

   // control state
   tss_state_type       state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [CW-1:0]       free_ff, free_in;
   logic [CW-1:0]       live_ff, live_in;
   logic                parity_ff, parity_in;
   logic [AW-1:0]       run_slot_ff, run_slot_in;
   logic                run_valid_ff, run_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // request being worked on and its pending result
   logic [TYPE_W-1:0]   op_ff, op_in;
   logic [OC_W-1:0]     oc_ff, oc_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [AW-1:0]       slot_ff, slot_in;
   logic                steal_ff, steal_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ID_W-1:0]     rid_ff, rid_in;
   logic                cflag_ff, cflag_in;
   logic                pflag_ff, pflag_in;
   rsp_payload_type     rsp_pl_ff, rsp_pl_in;

   // slot table and free-slot stack
   entry_type           tab_mem [SLOT_COUNT];
   entry_type           tab_rd_ff;
   logic                tab_we, tab_re;
   logic [AW-1:0]       tab_wa, tab_ra;
   entry_type           tab_wd;
   logic [AW-1:0]       free_mem [SLOT_COUNT];
   logic [AW-1:0]       free_rd_ff;
   logic                free_we, free_re;
   logic [AW-1:0]       free_wa, free_ra, free_wd;

   // ready rings and panic log
   rng_ctrl_type        main_ctrl, steal_ctrl, panic_ctrl;
   rng_stat_type        main_stat, steal_stat, panic_stat;
   logic [AW-1:0]       main_rd, steal_rd, ring_push_slot;
   logic [ID_W-1:0]     panic_rd, panic_push_id;

   // decode helpers
   entry_type           ent;
   logic [ID_W-1:0]     cur_id, spawn_id;
   logic [GEN_BITS-1:0] spawn_gen;
   logic                found;
   logic [SLOT_BITS-1:0] req_field, pan_field;
   logic                req_id_ok, pan_id_ok;

   tss_ring #(.DEPTH(SLOT_COUNT), .DW(AW)) u_main_ring (
      .clock, .reset, .ctrl(main_ctrl), .push_data(ring_push_slot),
      .rd_data(main_rd), .stat(main_stat)
   );

   tss_ring #(.DEPTH(SLOT_COUNT), .DW(AW)) u_steal_ring (
      .clock, .reset, .ctrl(steal_ctrl), .push_data(ring_push_slot),
      .rd_data(steal_rd), .stat(steal_stat)
   );

   tss_ring #(.DEPTH(SLOT_COUNT), .DW(ID_W)) u_panic_ring (
      .clock, .reset, .ctrl(panic_ctrl), .push_data(panic_push_id),
      .rd_data(panic_rd), .stat(panic_stat)
   );

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      ent       = tab_rd_ff;
      cur_id    = make_id(slot_ff, ent.gen);
      found     = ent.occ && (cur_id == id_ff);
      spawn_gen = ent.gen + 1'b1;
      if (spawn_gen == '0) begin
         // generation wraps to one so an id is never zero
         spawn_gen = GEN_BITS'(1);
      end
      spawn_id  = make_id(slot_ff, spawn_gen);
      req_field = req_ch.task_id[SLOT_BITS-1:0];
      req_id_ok = (req_ch.task_id != '0) && (32'(req_field) < SLOT_COUNT);
      pan_field = panic_rd[SLOT_BITS-1:0];
      pan_id_ok = (panic_rd != '0) && (32'(pan_field) < SLOT_COUNT);
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      free_in        = free_ff;
      live_in        = live_ff;
      parity_in      = parity_ff;
      run_slot_in    = run_slot_ff;
      run_valid_in   = run_valid_ff;
      op_in          = op_ff;
      oc_in          = oc_ff;
      id_in          = id_ff;
      slot_in        = slot_ff;
      steal_in       = steal_ff;
      status_in      = status_ff;
      rid_in         = rid_ff;
      cflag_in       = cflag_ff;
      pflag_in       = pflag_ff;
      rsp_pl_in      = rsp_pl_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      tab_we         = 1'b0;
      tab_wa         = slot_ff;
      tab_wd         = ent;
      tab_re         = 1'b0;
      tab_ra         = slot_ff;
      free_we        = 1'b0;
      free_wa        = AW'(free_ff);
      free_wd        = slot_ff;
      free_re        = 1'b0;
      free_ra        = AW'(free_ff - 1'b1);
      main_ctrl      = '0;
      steal_ctrl     = '0;
      panic_ctrl     = '0;
      ring_push_slot = slot_ff;
      panic_push_id  = cur_id;

      unique case (state_ff)
         S_CLEAR: begin
            // zero one table entry and seed one free-stack entry per cycle
            tab_we  = 1'b1;
            tab_wa  = clr_ff;
            tab_wd  = '0;
            free_we = 1'b1;
            free_wa = clr_ff;
            free_wd = AW'(SLOT_COUNT - 1) - clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (32'(clr_ff) == SLOT_COUNT - 1) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_ch.valid) begin
               op_in     = req_ch.req_type;
               oc_in     = req_ch.outcome;
               id_in     = req_ch.task_id;
               steal_in  = 1'b0;
               status_in = STAT_NOT_FOUND;
               rid_in    = '0;
               cflag_in  = 1'b0;
               pflag_in  = 1'b0;
               state_in  = S_OUT;
               unique case (req_ch.req_type)
                  REQ_SPAWN: begin
                     if (32'(live_ff) >= SLOT_COUNT || free_ff == '0) begin
                        status_in = STAT_NO_SLOT;
                     end else begin
                        // read the top of the free stack
                        free_re  = 1'b1;
                        state_in = S_FETCH;
                     end
                  end
                  REQ_DISPATCH: begin
                     // main ring first, then the steal ring
                     if (!run_valid_ff) begin
                        if (!main_stat.empty) begin
                           main_ctrl.pop = 1'b1;
                           state_in      = S_FETCH;
                        end else if (!steal_stat.empty) begin
                           steal_ctrl.pop = 1'b1;
                           steal_in       = 1'b1;
                           state_in       = S_FETCH;
                        end
                     end
                  end
                  REQ_RUN_END, REQ_FLAG_OP: begin
                     if (run_valid_ff && req_ch.outcome != OC_INVALID) begin
                        tab_re   = 1'b1;
                        tab_ra   = run_slot_ff;
                        slot_in  = run_slot_ff;
                        state_in = S_EVAL;
                     end
                  end
                  REQ_CANCEL, REQ_TAKE_DONE: begin
                     if (req_id_ok) begin
                        tab_re   = 1'b1;
                        tab_ra   = AW'(req_field);
                        slot_in  = AW'(req_field);
                        state_in = S_EVAL;
                     end
                  end
                  REQ_TAKE_PANIC: begin
                     if (!panic_stat.empty) begin
                        panic_ctrl.pop = 1'b1;
                        state_in       = S_FETCH;
                     end
                  end
                  default: begin
                     // unknown request: not found
                  end
               endcase
            end
         end

         S_FETCH: begin
            // ring or stack data is in; fetch the slot-table entry it names
            state_in = S_OUT;
            case (op_ff)
               REQ_SPAWN: begin
                  slot_in  = free_rd_ff;
                  tab_re   = 1'b1;
                  tab_ra   = free_rd_ff;
                  state_in = S_EVAL;
               end
               REQ_DISPATCH: begin
                  slot_in  = steal_ff ? steal_rd : main_rd;
                  tab_re   = 1'b1;
                  tab_ra   = steal_ff ? steal_rd : main_rd;
                  state_in = S_EVAL;
               end
               REQ_TAKE_PANIC: begin
                  id_in = panic_rd;
                  if (pan_id_ok) begin
                     slot_in  = AW'(pan_field);
                     tab_re   = 1'b1;
                     tab_ra   = AW'(pan_field);
                     state_in = S_EVAL;
                  end else if (!panic_stat.empty) begin
                     // drop the stale entry, try the next
                     panic_ctrl.pop = 1'b1;
                     state_in       = S_FETCH;
                  end
               end
               default: begin
               end
            endcase
         end

         S_EVAL: begin
            state_in = S_OUT;
            tab_wa   = slot_ff;
            case (op_ff)
               REQ_SPAWN: begin
                  // even ids go to the steal ring, odd ids to the main ring
                  if (spawn_id[0] ? main_stat.full : steal_stat.full) begin
                     status_in = STAT_OVERFLOW;
                  end else begin
                     tab_we     = 1'b1;
                     tab_wd     = '0;
                     tab_wd.gen = spawn_gen;
                     tab_wd.occ = 1'b1;
                     free_in    = free_ff - 1'b1;
                     live_in    = live_ff + 1'b1;
                     main_ctrl.push  = spawn_id[0];
                     steal_ctrl.push = !spawn_id[0];
                     status_in  = STAT_OK;
                     rid_in     = spawn_id;
                  end
               end
               REQ_DISPATCH: begin
                  tab_we       = 1'b1;
                  tab_wd.phase = PH_RUNNING;
                  run_slot_in  = slot_ff;
                  run_valid_in = 1'b1;
                  status_in    = STAT_OK;
                  rid_in       = cur_id;
               end
               REQ_RUN_END: begin
                  run_valid_in = 1'b0;
                  tab_we       = 1'b1;
                  status_in    = STAT_OK;
                  rid_in       = cur_id;
                  if (oc_ff == OC_YIELD) begin
                     // re-queue by alternating parity; left unqueued if full
                     tab_wd.phase = PH_SUSPENDED;
                     parity_in    = !parity_ff;
                     if (parity_ff ? main_stat.full : steal_stat.full) begin
                        status_in = STAT_OVERFLOW;
                        rid_in    = '0;
                     end else begin
                        main_ctrl.push  = parity_ff;
                        steal_ctrl.push = !parity_ff;
                     end
                  end else begin
                     tab_wd.phase = PH_DONE;
                     if (oc_ff == OC_PANIC) begin
                        tab_wd.pan      = 1'b1;
                        panic_ctrl.push = !panic_stat.full;
                     end
                  end
               end
               REQ_CANCEL: begin
                  if (found && ent.phase != PH_DONE) begin
                     tab_we      = 1'b1;
                     tab_wd.creq = 1'b1;
                     status_in   = STAT_OK;
                  end
               end
               REQ_TAKE_DONE, REQ_TAKE_PANIC: begin
                  if (found && ent.phase == PH_DONE &&
                      (op_ff == REQ_TAKE_DONE || ent.pan)) begin
                     // recycle: keep the generation, free everything else
                     tab_we     = 1'b1;
                     tab_wd     = '0;
                     tab_wd.gen = ent.gen;
                     if (32'(free_ff) < SLOT_COUNT) begin
                        free_we = 1'b1;
                        free_in = free_ff + 1'b1;
                     end
                     if (live_ff != '0) begin
                        live_in = live_ff - 1'b1;
                     end
                     status_in = STAT_OK;
                     rid_in    = id_ff;
                     cflag_in  = ent.cret;
                     pflag_in  = ent.pan;
                  end else if (op_ff == REQ_TAKE_PANIC && !panic_stat.empty) begin
                     panic_ctrl.pop = 1'b1;
                     state_in       = S_FETCH;
                  end
               end
               REQ_FLAG_OP: begin
                  rid_in = cur_id;
                  if (oc_ff == FLAG_READ) begin
                     cflag_in  = ent.creq;
                     status_in = ent.creq ? STAT_OK : STAT_NOT_FOUND;
                  end else begin
                     tab_we = 1'b1;
                     if (oc_ff == FLAG_MARK_RETURN) begin
                        tab_wd.cret = 1'b1;
                     end else begin
                        tab_wd.creq = 1'b1;
                     end
                     status_in = STAT_OK;
                  end
               end
               default: begin
               end
            endcase
         end

         S_OUT: begin
            // hold until the response register is free, then load it
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in             = 1'b1;
               rsp_pl_in.status         = status_ff;
               rsp_pl_in.result_id      = rid_ff;
               rsp_pl_in.cancelled_flag = cflag_ff;
               rsp_pl_in.panicked_flag  = pflag_ff;
               rsp_pl_in.from_steal     = steal_ff && status_ff == STAT_OK;
               rsp_pl_in.live_tasks     = LIVE_W'(live_ff);
               rsp_pl_in.work_pending   = !main_stat.empty || !steal_stat.empty;
               state_in                 = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // slot table: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[tab_wa] <= tab_wd;
      end
      if (tab_re) begin
         tab_rd_ff <= tab_mem[tab_ra];
      end
   end

   // free-slot stack
   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_wa] <= free_wd;
      end
      if (free_re) begin
         free_rd_ff <= free_mem[free_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_ff      <= CW'(SLOT_COUNT);
         live_ff      <= '0;
         parity_ff    <= 1'b0;
         run_slot_ff  <= '0;
         run_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         live_ff      <= live_in;
         parity_ff    <= parity_in;
         run_slot_ff  <= run_slot_in;
         run_valid_ff <= run_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      oc_ff     <= oc_in;
      id_ff     <= id_in;
      slot_ff   <= slot_in;
      steal_ff  <= steal_in;
      status_ff <= status_in;
      rid_ff    <= rid_in;
      cflag_ff  <= cflag_in;
      pflag_ff  <= pflag_in;
      rsp_pl_ff <= rsp_pl_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_pl_ff.status;
   assign rsp_ch.result_id      = rsp_pl_ff.result_id;
   assign rsp_ch.cancelled_flag = rsp_pl_ff.cancelled_flag;
   assign rsp_ch.panicked_flag  = rsp_pl_ff.panicked_flag;
   assign rsp_ch.from_steal     = rsp_pl_ff.from_steal;
   assign rsp_ch.live_tasks     = rsp_pl_ff.live_tasks;
   assign rsp_ch.work_pending   = rsp_pl_ff.work_pending;

   // every slot is either live or on the free stack
   `TSS_ASSERT_IMP(a_slot_balance, 1'b1, 32'(live_ff) + 32'(free_ff) == SLOT_COUNT)
   // a response appears only out of the output state
   `TSS_ASSERT_IMP(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff) == S_OUT)
   // a dispatch leaves a running task behind
   `TSS_ASSERT_NXT(a_dispatch_runs, state_ff == S_EVAL && op_ff == REQ_DISPATCH, run_valid_ff)
   // the main ring is never popped empty
   `TSS_ASSERT_IMP(a_main_pop_safe, main_ctrl.pop, !main_stat.empty)

endmodule

`default_nettype wire

### sim/task_slot_scheduler_tb.sv
`default_nettype none

module task_slot_scheduler_tb import tss_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 1024;
   localparam int NBITS = 10;
   localparam int GBITS = 21;
   localparam int LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tss_req_if req_ch ();
   tss_rsp_if rsp_ch ();

   task_slot_scheduler dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the scheduler state
   logic [GBITS-1:0] gen_tab [NSLOT];
   logic             occ_tab [NSLOT];
   logic [1:0]       phase_tab [NSLOT];
   logic             cxl_req_tab [NSLOT];
   logic             cxl_ret_tab [NSLOT];
   logic             pan_tab [NSLOT];
   int unsigned      free_stack [NSLOT];
   int unsigned      free_cnt;
   int unsigned      main_q [$];
   int unsigned      steal_q [$];
   logic [ID_W-1:0]  panic_log [$];
   logic             parity;
   int unsigned      live_cnt;
   int unsigned      run_slot;
   logic             run_valid;

   rsp_payload_type  pending_rsp [$];
   int unsigned      mismatches = 0;
   int unsigned      cycles = 0;
   logic             rsp_stall_on = 1'b1;

   function automatic logic [ID_W-1:0] task_id_of(int unsigned s, logic [GBITS-1:0] g);
      return ID_W'({g, NBITS'(s)});
   endfunction

   // Slot of a live task with this id, or -1
   function automatic int lookup_slot(logic [ID_W-1:0] id);
      int unsigned s;
      s = 32'(id[NBITS-1:0]);
      if (id == '0 || !occ_tab[s] || task_id_of(s, gen_tab[s]) != id) return -1;
      return int'(s);
   endfunction

   function automatic void recycle_slot(int unsigned s);
      occ_tab[s] = 1'b0;
      phase_tab[s] = PH_READY;
      cxl_req_tab[s] = 1'b0;
      cxl_ret_tab[s] = 1'b0;
      pan_tab[s] = 1'b0;
      if (free_cnt < NSLOT) begin
         free_stack[free_cnt] = s;
         free_cnt++;
      end
      if (live_cnt > 0) live_cnt--;
   endfunction

   function automatic void reset_shadow();
      for (int i = 0; i < NSLOT; i++) begin
         gen_tab[i] = '0; occ_tab[i] = 1'b0; phase_tab[i] = PH_READY;
         cxl_req_tab[i] = 1'b0; cxl_ret_tab[i] = 1'b0; pan_tab[i] = 1'b0;
         free_stack[i] = NSLOT - 1 - i;
      end
      free_cnt = NSLOT;
      main_q.delete(); steal_q.delete(); panic_log.delete();
      parity = 1'b0; live_cnt = 0; run_slot = 0; run_valid = 1'b0;
   endfunction

   // Advance the shadow by one request and return the response it causes
   function automatic rsp_payload_type schedule_step(logic [2:0] kind, logic [ID_W-1:0] tid,
                                                     logic [1:0] oc);
      rsp_payload_type r;
      int unsigned s;
      int f;
      logic [GBITS-1:0] g;
      logic [ID_W-1:0] id;
      r = '0;
      r.status = STAT_NOT_FOUND;
      case (kind)
         REQ_SPAWN: begin
            if (live_cnt >= NSLOT || free_cnt == 0) begin
               r.status = STAT_NO_SLOT;
            end else begin
               s = free_stack[free_cnt-1];
               g = gen_tab[s] + 1'b1;
               if (g == '0) g = GBITS'(1);
               id = task_id_of(s, g);
               if ((id[0] ? main_q.size() : steal_q.size()) >= NSLOT) begin
                  r.status = STAT_OVERFLOW;
               end else begin
                  free_cnt--;
                  gen_tab[s] = g; occ_tab[s] = 1'b1; phase_tab[s] = PH_READY;
                  cxl_req_tab[s] = 1'b0; cxl_ret_tab[s] = 1'b0; pan_tab[s] = 1'b0;
                  live_cnt++;
                  if (id[0]) main_q.push_back(s);
                  else steal_q.push_back(s);
                  r.status = STAT_OK;
                  r.result_id = id;
               end
            end
         end
         REQ_DISPATCH: begin
            if (!run_valid && (main_q.size() > 0 || steal_q.size() > 0)) begin
               if (main_q.size() > 0) s = main_q.pop_front();
               else begin
                  s = steal_q.pop_front();
                  r.from_steal = 1'b1;
               end
               phase_tab[s] = PH_RUNNING;
               run_slot = s; run_valid = 1'b1;
               r.result_id = task_id_of(s, gen_tab[s]);
               r.status = STAT_OK;
            end
         end
         REQ_RUN_END: begin
            if (run_valid && oc != OC_INVALID) begin
               s = run_slot;
               run_valid = 1'b0;
               r.result_id = task_id_of(s, gen_tab[s]);
               r.status = STAT_OK;
               if (oc == OC_YIELD) begin
                  phase_tab[s] = PH_SUSPENDED;
                  if ((parity ? main_q.size() : steal_q.size()) >= NSLOT) begin
                     r.status = STAT_OVERFLOW; r.result_id = '0;
                  end else if (parity) main_q.push_back(s);
                  else steal_q.push_back(s);
                  parity = ~parity;
               end else begin
                  phase_tab[s] = PH_DONE;
                  if (oc == OC_PANIC) begin
                     pan_tab[s] = 1'b1;
                     if (panic_log.size() < NSLOT) panic_log.push_back(r.result_id);
                  end
               end
            end
         end
         REQ_CANCEL: begin
            f = lookup_slot(tid);
            if (f >= 0 && phase_tab[f] != PH_DONE) begin
               cxl_req_tab[f] = 1'b1;
               r.status = STAT_OK;
            end
         end
         REQ_TAKE_DONE: begin
            f = lookup_slot(tid);
            if (f >= 0 && phase_tab[f] == PH_DONE) begin
               r.result_id = tid;
               r.cancelled_flag = cxl_ret_tab[f];
               r.panicked_flag = pan_tab[f];
               recycle_slot(32'(f));
               r.status = STAT_OK;
            end
         end
         REQ_TAKE_PANIC: begin
            while (panic_log.size() > 0) begin
               id = panic_log.pop_front();
               f = lookup_slot(id);
               if (f >= 0 && phase_tab[f] == PH_DONE && pan_tab[f]) begin
                  r.result_id = id;
                  r.cancelled_flag = cxl_ret_tab[f];
                  r.panicked_flag = 1'b1;
                  recycle_slot(32'(f));
                  r.status = STAT_OK;
                  break;
               end
            end
         end
         REQ_FLAG_OP: begin
            if (run_valid && oc != OC_INVALID) begin
               s = run_slot;
               r.result_id = task_id_of(s, gen_tab[s]);
               if (oc == FLAG_READ) begin
                  r.cancelled_flag = cxl_req_tab[s];
                  r.status = cxl_req_tab[s] ? STAT_OK : STAT_NOT_FOUND;
               end else begin
                  if (oc == FLAG_MARK_RETURN) cxl_ret_tab[s] = 1'b1;
                  else cxl_req_tab[s] = 1'b1;
                  r.status = STAT_OK;
               end
            end
         end
         default: ;
      endcase
      r.live_tasks = LIVE_W'(live_cnt);
      r.work_pending = (main_q.size() > 0 || steal_q.size() > 0);
      return r;
   endfunction

   // Directed table: a typed expectation is checked against the predictor's own answer
   typedef struct {
      logic [2:0]       kind;
      logic [ID_W-1:0]  tid;
      logic [1:0]       oc;
      logic             typed;
      rsp_payload_type  want;
   } directed_row_type;

   directed_row_type dir_tab [$];

   function automatic rsp_payload_type typed_rsp(logic [1:0] st, logic [ID_W-1:0] id,
                                                 int unsigned live, logic wp);
      rsp_payload_type r;
      r = '0;
      r.status = st; r.result_id = id; r.live_tasks = LIVE_W'(live); r.work_pending = wp;
      return r;
   endfunction

   function automatic void add_row(logic [2:0] k, logic [ID_W-1:0] t, logic [1:0] o,
                                   logic ty = 1'b0, rsp_payload_type w = '0);
      directed_row_type d;
      d.kind = k; d.tid = t; d.oc = o; d.typed = ty; d.want = w;
      dir_tab.push_back(d);
   endfunction

   task automatic drive_idle();
      req_ch.valid <= 1'b0;
      req_ch.req_type <= '0;
      req_ch.task_id <= '0;
      req_ch.outcome <= '0;
   endtask

   // Present one request at the falling edge, hold until accepted, then predict
   task automatic send_request(logic [2:0] k, logic [ID_W-1:0] t, logic [1:0] o,
                               logic gaps, logic ty = 1'b0,
                               rsp_payload_type w = '0);
      rsp_payload_type p;
      if (gaps && $urandom_range(0, 3) == 0) begin
         drive_idle();
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= k;
      req_ch.task_id <= t;
      req_ch.outcome <= o;
      do @(posedge clock); while (!req_ch.ready);
      p = schedule_step(k, t, o);
      if (ty && p != w) begin
         mismatches++;
         if (mismatches <= 10)
            $display("directed row disagrees: table %p, predicted %p", w, p);
      end
      pending_rsp.push_back(p);
      @(negedge clock);
   endtask

   // Pick an id: mostly a live or recently seen task, sometimes noise
   logic [ID_W-1:0] seen_ids [$];

   function automatic logic [ID_W-1:0] pick_id();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 7 && seen_ids.size() > 0)
         return seen_ids[$urandom_range(0, seen_ids.size() - 1)];
      else if (sel == 7) return ID_W'($urandom);
      else if (sel == 8) return '1;
      return '0;
   endfunction

   // Response checking: sample at the rising edge
   always @(posedge clock) begin
      rsp_payload_type got, exp_r;
      if (!reset) begin
         cycles <= cycles + 1;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status = rsp_ch.status;
            got.result_id = rsp_ch.result_id;
            got.cancelled_flag = rsp_ch.cancelled_flag;
            got.panicked_flag = rsp_ch.panicked_flag;
            got.from_steal = rsp_ch.from_steal;
            got.live_tasks = rsp_ch.live_tasks;
            got.work_pending = rsp_ch.work_pending;
            if (got.status == STAT_OK && got.result_id != '0) seen_ids.push_back(got.result_id);
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", got);
            end else begin
               exp_r = pending_rsp.pop_front();
               if (got !== exp_r) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response mismatch: expected %p, actual %p", exp_r, got);
               end
            end
         end
      end
   end

   // Result-side stalls in random bursts, none in the last part of the random run
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_stall_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Watchdog: covers the clearing pass and slow stalled handshakes many times over
   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("task_slot_scheduler_tb failed");
         $finish;
      end
   end

   initial begin
      int unsigned k;
      logic [ID_W-1:0] first_id;
      drive_idle();
      reset_shadow();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Extremes after reset: empty scheduler answers not found everywhere
      add_row(REQ_DISPATCH, '0, '0, 1'b1, typed_rsp(STAT_NOT_FOUND, '0, 0, 1'b0));
      add_row(REQ_RUN_END, '0, OC_FINISH, 1'b1, typed_rsp(STAT_NOT_FOUND, '0, 0, 1'b0));
      add_row(REQ_FLAG_OP, '0, FLAG_READ, 1'b1, typed_rsp(STAT_NOT_FOUND, '0, 0, 1'b0));
      add_row(REQ_CANCEL, '1, '0, 1'b1, typed_rsp(STAT_NOT_FOUND, '0, 0, 1'b0));
      add_row(REQ_TAKE_DONE, '0, '0, 1'b1, typed_rsp(STAT_NOT_FOUND, '0, 0, 1'b0));
      add_row(REQ_TAKE_PANIC, '0, '0, 1'b1, typed_rsp(STAT_NOT_FOUND, '0, 0, 1'b0));
      add_row(REQ_UNKNOWN, '1, OC_INVALID, 1'b1, typed_rsp(STAT_NOT_FOUND, '0, 0, 1'b0));
      // First spawn takes slot 0 at generation 1: id 1024, even, steal ring
      first_id = ID_W'(1 << NBITS);
      add_row(REQ_SPAWN, '0, '0, 1'b1, typed_rsp(STAT_OK, first_id, 1, 1'b1));
      add_row(REQ_SPAWN, '0, '0);
      add_row(REQ_DISPATCH, '0, '0);
      add_row(REQ_RUN_END, '0, OC_INVALID);
      add_row(REQ_FLAG_OP, '0, OC_INVALID);
      add_row(REQ_FLAG_OP, '0, FLAG_SELF_CANCEL);
      add_row(REQ_FLAG_OP, '0, FLAG_READ);
      add_row(REQ_FLAG_OP, '0, FLAG_MARK_RETURN);
      add_row(REQ_DISPATCH, '0, '0);
      add_row(REQ_RUN_END, '0, OC_YIELD);
      add_row(REQ_DISPATCH, '0, '0);
      add_row(REQ_RUN_END, '0, OC_PANIC);
      add_row(REQ_DISPATCH, '0, '0);
      add_row(REQ_RUN_END, '0, OC_FINISH);
      add_row(REQ_CANCEL, first_id, '0);
      add_row(REQ_TAKE_DONE, first_id, '0);
      add_row(REQ_TAKE_PANIC, '0, '0);
      add_row(REQ_TAKE_PANIC, '0, '0);

      foreach (dir_tab[i])
         send_request(dir_tab[i].kind, dir_tab[i].tid, dir_tab[i].oc, 1'b1,
                      dir_tab[i].typed, dir_tab[i].want);

      // Hold the sender until every response is back
      drive_idle();
      wait (pending_rsp.size() == 0);
      @(negedge clock);

      // Random part: task life cycles mostly, with noise; last part without gaps
      for (int n = 0; n < 500; n++) begin
         logic gaps;
         gaps = (n < 420);
         if (n == 420) rsp_stall_on <= 1'b0;
         k = $urandom_range(0, 99);
         if (k < 20)      send_request(REQ_SPAWN, ID_W'($urandom), 2'($urandom), gaps);
         else if (k < 40) send_request(REQ_DISPATCH, ID_W'($urandom), 2'($urandom), gaps);
         else if (k < 58) send_request(REQ_RUN_END, '0,
                                       (k < 56) ? 2'($urandom_range(0, 2)) : OC_INVALID,
                                       gaps);
         else if (k < 66) send_request(REQ_CANCEL, pick_id(), '0, gaps);
         else if (k < 78) send_request(REQ_TAKE_DONE, pick_id(), 2'($urandom), gaps);
         else if (k < 85) send_request(REQ_TAKE_PANIC, ID_W'($urandom), '0, gaps);
         else if (k < 97) send_request(REQ_FLAG_OP, '0, 2'($urandom), gaps);
         else             send_request(REQ_UNKNOWN, ID_W'($urandom), 2'($urandom), gaps);
      end

      drive_idle();
      wait (pending_rsp.size() == 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("task_slot_scheduler_tb passed");
      end else begin
         $display("task_slot_scheduler_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/tss_pkg.sv
rtl/tss_req_if.sv
rtl/tss_rsp_if.sv
rtl/tss_ring.sv
rtl/task_slot_scheduler.sv
sim/task_slot_scheduler_tb.sv
